### rtl/vcoc_pkg.sv
// Package for the voxel column obstacle classifier.
// Holds the field widths, the lane split, the verdict codes and the lane summary type.
// No dependencies.
`default_nettype none

package vcoc_pkg;

  // Column geometry
  localparam int LAYERS = 32;
  localparam int COL_W  = 32;
  localparam int CELL_W = 12;
  localparam int LAYER_W = 5;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 3;

  // Occupied bits at or above LAYERS read as free
  localparam logic [COL_W-1:0] LAYER_MASK =
      (LAYERS >= COL_W) ? {COL_W{1'b1}} : COL_W'((64'd1 << LAYERS) - 64'd1);

  // Lane split: each lane scans one byte of the column
  localparam int LANE_W     = 8;
  localparam int NUM_LANES  = COL_W / LANE_W;
  localparam int LANE_IDX_W = $clog2(LANE_W);
  localparam int LANE_SEL_W = $clog2(NUM_LANES);
  localparam int LANE_CNT_W = $clog2(LANE_W) + 1;
  localparam int HOLE_W     = LAYER_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_SPAN_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_SPAN_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_OFFSET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAISED_BASE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_LIMIT        = 3'd4;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_GROUND_SPAN_MIN   = 7'd2;
  localparam logic [CFG_W-1:0] RST_SHORT_SPAN_LIMIT  = 7'd3;
  localparam logic [CFG_W-1:0] RST_LAYER_OFFSET      = 7'd7;
  localparam logic [CFG_W-1:0] RST_RAISED_BASE_LIMIT = 7'd4;
  localparam logic [CFG_W-1:0] RST_HOLE_LIMIT        = 7'd3;

  typedef enum logic [2:0] {
    VERDICT_KEPT   = 3'd0,
    VERDICT_EMPTY  = 3'd1,
    VERDICT_GROUND = 3'd2,
    VERDICT_RAISED = 3'd3,
    VERDICT_HOLE   = 3'd4
  } verdict_t;

  // What one lane found in its byte
  typedef struct packed {
    logic                  any;
    logic [LANE_IDX_W-1:0] lo;
    logic [LANE_IDX_W-1:0] hi;
    logic [LANE_CNT_W-1:0] hole;
  } lane_sum_t;

  typedef struct packed {
    logic [CFG_W-1:0] ground_span_min;
    logic [CFG_W-1:0] short_span_limit;
    logic [CFG_W-1:0] layer_offset;
    logic [CFG_W-1:0] raised_base_limit;
    logic [CFG_W-1:0] hole_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic                 keep;
    verdict_t             verdict;
    logic [LAYER_W-1:0]   lowest_layer;
    logic [LAYER_W-1:0]   highest_layer;
    logic [LAYER_W-1:0]   span_layers;
    logic [LAYER_W-1:0]   longest_hole;
  } col_result_t;

endpackage

`default_nettype wire

### rtl/vcoc_if.sv
// Channel interfaces for the voxel column obstacle classifier.
// Column input, result output and register write channels; depends on vcoc_pkg.
`default_nettype none

interface vcoc_col_if;
  logic                        valid;
  logic                        ready;
  logic [vcoc_pkg::COL_W-1:0]  column_bits;
  logic [vcoc_pkg::CELL_W-1:0] cell_x;
  logic [vcoc_pkg::CELL_W-1:0] cell_y;

  modport source (output valid, column_bits, cell_x, cell_y, input ready);
  modport sink   (input valid, column_bits, cell_x, cell_y, output ready);
endinterface

interface vcoc_res_if;
  logic                         valid;
  logic                         ready;
  logic                         keep;
  logic [2:0]                   verdict;
  logic [vcoc_pkg::LAYER_W-1:0] lowest_layer;
  logic [vcoc_pkg::LAYER_W-1:0] highest_layer;
  logic [vcoc_pkg::LAYER_W-1:0] span_layers;
  logic [vcoc_pkg::LAYER_W-1:0] longest_hole;
  logic [vcoc_pkg::CELL_W-1:0]  out_x;
  logic [vcoc_pkg::CELL_W-1:0]  out_y;

  modport source (output valid, keep, verdict, lowest_layer, highest_layer, span_layers,
                  longest_hole, out_x, out_y, input ready);
  modport sink   (input valid, keep, verdict, lowest_layer, highest_layer, span_layers,
                  longest_hole, out_x, out_y, output ready);
endinterface

interface vcoc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vcoc_pkg::CFG_IDX_W-1:0] index;
  logic [vcoc_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/vcoc_lane.sv
// One scan lane: lowest and highest occupied bit and longest inner free run of a byte.
// Depends on vcoc_pkg.
`default_nettype none

module vcoc_lane (
  input  wire logic [vcoc_pkg::LANE_W-1:0] bits,
  output vcoc_pkg::lane_sum_t              sum
);

  always_comb begin
    logic [vcoc_pkg::LANE_CNT_W-1:0] run;
    logic [vcoc_pkg::LANE_CNT_W-1:0] hole;
    logic                            seen;
    logic [vcoc_pkg::LANE_IDX_W-1:0] lo;
    logic [vcoc_pkg::LANE_IDX_W-1:0] hi;
    run  = '0;
    hole = '0;
    seen = 1'b0;
    lo   = '0;
    hi   = '0;
    for (int z = 0; z < vcoc_pkg::LANE_W; z++) begin
      if (bits[z]) begin
        // close a run only when it sits between two occupied bits
        if (seen && run > hole) begin
          hole = run;
        end
        seen = 1'b1;
        run  = '0;
        hi   = vcoc_pkg::LANE_IDX_W'(z);
      end else begin
        run = run + 1'b1;
      end
    end
    for (int z = vcoc_pkg::LANE_W - 1; z >= 0; z--) begin
      if (bits[z]) begin
        lo = vcoc_pkg::LANE_IDX_W'(z);
      end
    end
    sum.any  = seen;
    sum.lo   = lo;
    sum.hi   = hi;
    sum.hole = hole;
  end

endmodule

`default_nettype wire

### rtl/vcoc_merge.sv
// Merge stage: combines the lane summaries into the column measures and the verdict.
// Depends on vcoc_pkg.
`default_nettype none

module vcoc_merge (
  input  vcoc_pkg::lane_sum_t   lanes [vcoc_pkg::NUM_LANES],
  input  vcoc_pkg::cfg_regs_t   regs,
  output vcoc_pkg::col_result_t res
);

  logic [vcoc_pkg::LAYER_W-1:0] lo;
  logic [vcoc_pkg::LAYER_W-1:0] hi;
  logic [vcoc_pkg::HOLE_W-1:0]  hole;
  logic                         any;
  logic [vcoc_pkg::LAYER_W-1:0] span;
  logic signed [vcoc_pkg::CFG_W+1:0] base_diff;
  logic                         is_ground;
  logic                         is_raised;
  logic                         is_hole;

  // Walk the lanes bottom up, carrying the free run that leaves the last occupied lane
  always_comb begin
    logic [vcoc_pkg::HOLE_W-1:0] pend;
    logic [vcoc_pkg::HOLE_W-1:0] cand;
    logic                        seen;
    pend = '0;
    cand = '0;
    seen = 1'b0;
    hole = '0;
    hi   = '0;
    for (int l = 0; l < vcoc_pkg::NUM_LANES; l++) begin
      if (lanes[l].any) begin
        if (seen) begin
          cand = pend + vcoc_pkg::HOLE_W'(lanes[l].lo);
          if (cand > hole) begin
            hole = cand;
          end
        end
        if (vcoc_pkg::HOLE_W'(lanes[l].hole) > hole) begin
          hole = vcoc_pkg::HOLE_W'(lanes[l].hole);
        end
        seen = 1'b1;
        pend = vcoc_pkg::HOLE_W'(vcoc_pkg::LANE_W - 1) - vcoc_pkg::HOLE_W'(lanes[l].hi);
        hi   = {vcoc_pkg::LANE_SEL_W'(l), lanes[l].hi};
      end else begin
        pend = pend + vcoc_pkg::HOLE_W'(vcoc_pkg::LANE_W);
      end
    end
    any = seen;
  end

  always_comb begin
    lo = '0;
    for (int l = vcoc_pkg::NUM_LANES - 1; l >= 0; l--) begin
      if (lanes[l].any) begin
        lo = {vcoc_pkg::LANE_SEL_W'(l), lanes[l].lo};
      end
    end
  end

  assign span      = hi - lo;
  assign base_diff = $signed({4'b0, lo}) - $signed({2'b0, regs.layer_offset});
  assign is_ground = {2'b0, span} < regs.ground_span_min;
  assign is_raised = ({2'b0, span} < regs.short_span_limit) &&
                     (base_diff > $signed({2'b0, regs.raised_base_limit}));
  assign is_hole   = {1'b0, hole} > regs.hole_limit;

  always_comb begin
    vcoc_pkg::verdict_t v;
    if (!any) begin
      v = vcoc_pkg::VERDICT_EMPTY;
    end else if (is_ground) begin
      v = vcoc_pkg::VERDICT_GROUND;
    end else if (is_raised) begin
      v = vcoc_pkg::VERDICT_RAISED;
    end else if (is_hole) begin
      v = vcoc_pkg::VERDICT_HOLE;
    end else begin
      v = vcoc_pkg::VERDICT_KEPT;
    end
    res.verdict       = v;
    res.keep          = (v == vcoc_pkg::VERDICT_KEPT);
    res.lowest_layer  = lo;
    res.highest_layer = hi;
    res.span_layers   = span;
    res.longest_hole  = hole[vcoc_pkg::LAYER_W-1:0];
  end

endmodule

`default_nettype wire

### rtl/voxel_column_obstacle_classifier_top.sv
// Top level of the voxel column obstacle classifier.
// Depends on vcoc_pkg, the channel interfaces, vcoc_lane and vcoc_merge.
`default_nettype none

// Classifies one map column per clock unless res_out stalls. A transfer on
// col_in carries the occupied bits of the column's layers plus its x/y cell;
// via the lane register and the result register the result reaches res_out
// with the lowest and highest occupied layer, their span, the longest free
// run between them and a verdict (kept, empty, ground, short and raised, hole
// too large; the first failing check wins). Four byte-wide scan lanes feed
// the lane register, the merge logic feeds the result register. The lane stage
// loads while empty, so a new column is taken while a finished result waits
// on res_out if the lane register is free. The five thresholds are written
// through cfg (index 0..4 in the order ground_span_min, short_span_limit,
// layer_offset, raised_base_limit, hole_limit); write them only while the
// block is idle. Writes to other indexes are dropped. cfg is always ready.

module voxel_column_obstacle_classifier_top (
  input  wire logic clk,
  input  wire logic rst,
  vcoc_col_if.sink   col_in,
  vcoc_res_if.source res_out,
  vcoc_cfg_if.sink   cfg
);

  // Threshold registers
  vcoc_pkg::cfg_regs_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ground_span_min   <= vcoc_pkg::RST_GROUND_SPAN_MIN;
      regs.short_span_limit  <= vcoc_pkg::RST_SHORT_SPAN_LIMIT;
      regs.layer_offset      <= vcoc_pkg::RST_LAYER_OFFSET;
      regs.raised_base_limit <= vcoc_pkg::RST_RAISED_BASE_LIMIT;
      regs.hole_limit        <= vcoc_pkg::RST_HOLE_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.index)
        vcoc_pkg::REG_GROUND_SPAN_MIN:   regs.ground_span_min   <= cfg.data;
        vcoc_pkg::REG_SHORT_SPAN_LIMIT:  regs.short_span_limit  <= cfg.data;
        vcoc_pkg::REG_LAYER_OFFSET:      regs.layer_offset      <= cfg.data;
        vcoc_pkg::REG_RAISED_BASE_LIMIT: regs.raised_base_limit <= cfg.data;
        vcoc_pkg::REG_HOLE_LIMIT:        regs.hole_limit        <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Handshake: each stage loads when it is empty or its content moves on
  logic s1_valid;
  logic out_valid;
  logic out_advance;
  logic s1_load;

  assign out_advance  = !out_valid || res_out.ready;
  assign s1_load      = !s1_valid || out_advance;
  assign col_in.ready = s1_load;

  // Lane stage: scan each byte of the masked column in parallel
  logic [vcoc_pkg::COL_W-1:0] col_masked;
  vcoc_pkg::lane_sum_t        lane_sum [vcoc_pkg::NUM_LANES];
  vcoc_pkg::lane_sum_t        s1_lane  [vcoc_pkg::NUM_LANES];
  logic [vcoc_pkg::CELL_W-1:0] s1_x;
  logic [vcoc_pkg::CELL_W-1:0] s1_y;

  assign col_masked = col_in.column_bits & vcoc_pkg::LAYER_MASK;

  for (genvar l = 0; l < vcoc_pkg::NUM_LANES; l++) begin : g_lane
    vcoc_lane u_lane (
      .bits (col_masked[l*vcoc_pkg::LANE_W +: vcoc_pkg::LANE_W]),
      .sum  (lane_sum[l])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= col_in.valid;
    end
  end

  // Payload holds while the stage is stalled
  always_ff @(posedge clk) begin
    if (s1_load && col_in.valid) begin
      s1_lane <= lane_sum;
      s1_x    <= col_in.cell_x;
      s1_y    <= col_in.cell_y;
    end
  end

  // Merge stage: combine the lanes and classify
  vcoc_pkg::col_result_t merged;
  vcoc_pkg::col_result_t out_res;
  logic [vcoc_pkg::CELL_W-1:0] out_x;
  logic [vcoc_pkg::CELL_W-1:0] out_y;

  vcoc_merge u_merge (
    .lanes (s1_lane),
    .regs  (regs),
    .res   (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      out_res <= merged;
      out_x   <= s1_x;
      out_y   <= s1_y;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.keep          = out_res.keep;
  assign res_out.verdict       = out_res.verdict;
  assign res_out.lowest_layer  = out_res.lowest_layer;
  assign res_out.highest_layer = out_res.highest_layer;
  assign res_out.span_layers   = out_res.span_layers;
  assign res_out.longest_hole  = out_res.longest_hole;
  assign res_out.out_x         = out_x;
  assign res_out.out_y         = out_y;

endmodule

`default_nettype wire
